/* src/asp_pkg.sv */
// Shared types and constants for the Ackermann steering PID core.
`default_nettype none
package asp_pkg;

  typedef struct packed {
    logic signed [14:0] steer_request;
    logic signed [15:0] left_angle;
    logic signed [15:0] left_rate;
    logic signed [15:0] right_angle;
    logic signed [15:0] right_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] left_force;
    logic signed [31:0] right_force;
  } out_item_t;

  localparam logic [2:0] REG_PROP   = 3'd0;
  localparam logic [2:0] REG_INTEG  = 3'd1;
  localparam logic [2:0] REG_DERIV  = 3'd2;
  localparam logic [2:0] REG_SMOOTH = 3'd3;
  localparam logic [2:0] REG_SNAP   = 3'd4;
  localparam logic [2:0] REG_TRACK  = 3'd5;

  localparam int TAB_LEN = 24;
  localparam logic signed [14:0] REQ_LIMIT = 15'sd12867;

  // Datapath operations issued by the controller.
  localparam logic [3:0] OP_LOAD   = 4'd0;
  localparam logic [3:0] OP_ROT    = 4'd1;
  localparam logic [3:0] OP_TRACK  = 4'd2;
  localparam logic [3:0] OP_VEC    = 4'd3;
  localparam logic [3:0] OP_ROUND  = 4'd4;
  localparam logic [3:0] OP_SMOOTH = 4'd5;
  localparam logic [3:0] OP_SNAP   = 4'd6;
  localparam logic [3:0] OP_INTEG  = 4'd7;
  localparam logic [3:0] OP_PTERM  = 4'd8;
  localparam logic [3:0] OP_ITERM  = 4'd9;
  localparam logic [3:0] OP_DTERM  = 4'd10;
  localparam logic [3:0] OP_FORCE  = 4'd11;

  typedef struct packed {
    logic [3:0] op;
    logic       wheel;   // 0 left, 1 right
    logic [4:0] iter;
  } cmd_t;

  function automatic logic signed [27:0] atan_entry(input logic [4:0] i);
    logic signed [27:0] v;
    unique case (i)
      5'd0: v = 28'sd13176795;
      5'd1: v = 28'sd7778716;
      5'd2: v = 28'sd4110060;
      5'd3: v = 28'sd2086331;
      5'd4: v = 28'sd1047214;
      5'd5: v = 28'sd524117;
      5'd6: v = 28'sd262123;
      5'd7: v = 28'sd131069;
      default: v = (i < 5'd24) ? (28'sd65536 >>> (i - 5'd8)) : 28'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* src/asp_datapath.sv */
// Datapath: shared CORDIC, the multipliers and wheel state registers.
`default_nettype none
module asp_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire asp_pkg::cmd_t       cmd,
  input  wire logic                cmd_valid,
  input  wire asp_pkg::in_item_t   item,
  input  wire logic [23:0]         prop_gain,
  input  wire logic [23:0]         integ_gain,
  input  wire logic [23:0]         deriv_gain,
  input  wire logic [15:0]         smooth_coef,
  input  wire logic [14:0]         snap_limit,
  input  wire logic [15:0]         track_ratio,
  output logic signed [31:0]       force_out
);

  logic signed [27:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [14:0] lt_r, lt_nxt, rt_r, rt_nxt, s_r, s_nxt;
  logic signed [31:0] ldes_r, ldes_nxt, rdes_r, rdes_nxt, lint_r, lint_nxt, rint_r, rint_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [31:0] force_r, force_nxt;
  asp_pkg::in_item_t  item_r, item_nxt;

  logic signed [27:0] xs, ys, at;
  logic signed [14:0] a13, sc, oa;
  logic signed [33:0] t34, d34, diff, nd, ad, e29, ang;
  logic signed [50:0] prod_s;
  logic signed [33:0] e13;
  logic signed [34:0] isum;
  logic signed [31:0] des, integ;
  logic signed [15:0] angle, rate;
  logic signed [63:0] fsum;
  logic signed [51:0] fsh;
  logic signed [44:0] trk_p;
  logic signed [58:0] kp_p;
  logic signed [56:0] ki_p;
  logic signed [40:0] kd_p;

  always_comb begin
    sc = item.steer_request;
    if (sc > asp_pkg::REQ_LIMIT) sc = asp_pkg::REQ_LIMIT;
    if (sc < -asp_pkg::REQ_LIMIT) sc = -asp_pkg::REQ_LIMIT;
    a13 = (sc < 0) ? -sc : sc;
    xs = x_r >>> cmd.iter;
    ys = y_r >>> cmd.iter;
    at = asp_pkg::atan_entry(cmd.iter);
    oa = 15'((z_r + 28'sd1024) >>> 11);
    des = cmd.wheel ? rdes_r : ldes_r;
    integ = cmd.wheel ? rint_r : lint_r;
    // The wheel measurements come from the copy taken when the transfer was accepted.
    angle = cmd.wheel ? item_r.right_angle : item_r.left_angle;
    rate = cmd.wheel ? item_r.right_rate : item_r.left_rate;
    t34 = 34'(cmd.wheel ? rt_r : lt_r) <<< 16;
    d34 = 34'(des);
    diff = t34 - d34;
    prod_s = $signed({1'b0, smooth_coef}) * diff;
    nd = d34 + 34'(prod_s >>> 16);
    ad = ((t34 - d34) < 0) ? (d34 - t34) : (t34 - d34);
    ang = 34'(angle) <<< 16;
    e29 = d34 - ang;
    e13 = (e29 + 34'sd32768) >>> 16;
    isum = 35'(integ) + 35'(e13);
    fsum = acc_r + 64'sd2048;
    fsh = 52'(fsum >>> 12);
    trk_p = $signed({1'b0, track_ratio}) * y_r;
    kp_p = $signed({1'b0, prop_gain}) * e29;
    ki_p = $signed({1'b0, integ_gain}) * integ;
    kd_p = $signed({1'b0, deriv_gain}) * rate;

    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    lt_nxt = lt_r; rt_nxt = rt_r; s_nxt = s_r;
    ldes_nxt = ldes_r; rdes_nxt = rdes_r; lint_nxt = lint_r; rint_nxt = rint_r;
    acc_nxt = acc_r; force_nxt = force_r; item_nxt = item_r;
    if (cmd_valid) begin
      unique case (cmd.op)
        asp_pkg::OP_LOAD: begin
          s_nxt = sc;
          item_nxt = item;
          x_nxt = 28'sd16777216; y_nxt = '0; z_nxt = 28'(a13) <<< 11;
          lt_nxt = '0; rt_nxt = '0;
        end
        asp_pkg::OP_ROT: begin
          if (z_r >= 0) begin
            x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - at;
          end else begin
            x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + at;
          end
        end
        asp_pkg::OP_TRACK: begin
          x_nxt = x_r + 28'(trk_p >>> 15);
          z_nxt = '0;
        end
        asp_pkg::OP_VEC: begin
          if (y_r >= 0) begin
            x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + at;
          end else begin
            x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - at;
          end
        end
        asp_pkg::OP_ROUND: begin
          if (s_r > 0) begin
            lt_nxt = s_r; rt_nxt = oa;
          end else if (s_r < 0) begin
            lt_nxt = -oa; rt_nxt = s_r;
          end
        end
        asp_pkg::OP_SMOOTH: begin
          if (cmd.wheel) rdes_nxt = 32'(nd); else ldes_nxt = 32'(nd);
        end
        asp_pkg::OP_SNAP: begin
          if (ad < (34'($signed({1'b0, snap_limit})) <<< 16)) begin
            if (cmd.wheel) rdes_nxt = 32'(t34); else ldes_nxt = 32'(t34);
          end
        end
        asp_pkg::OP_INTEG: begin
          if (isum > 35'sd2147483647) isum = 35'sd2147483647;
          if (isum < -35'sd2147483648) isum = -35'sd2147483648;
          if (cmd.wheel) rint_nxt = 32'(isum); else lint_nxt = 32'(isum);
        end
        asp_pkg::OP_PTERM:
          acc_nxt = 64'(kp_p >>> 16);
        asp_pkg::OP_ITERM:
          acc_nxt = acc_r + 64'(ki_p);
        asp_pkg::OP_DTERM:
          acc_nxt = acc_r - (64'(kd_p) <<< 2);
        asp_pkg::OP_FORCE: begin
          if (fsh > 52'sd2147483647) force_nxt = 32'sh7fffffff;
          else if (fsh < -52'sd2147483648) force_nxt = 32'sh80000000;
          else force_nxt = 32'(fsh);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ldes_r <= '0; rdes_r <= '0; lint_r <= '0; rint_r <= '0;
    end else begin
      ldes_r <= ldes_nxt; rdes_r <= rdes_nxt; lint_r <= lint_nxt; rint_r <= rint_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
    lt_r <= lt_nxt; rt_r <= rt_nxt; s_r <= s_nxt;
    acc_r <= acc_nxt; force_r <= force_nxt; item_r <= item_nxt;
  end

  assign force_out = force_r;

endmodule
`default_nettype wire

/* src/asp_control.sv */
// Controller: sequences CORDIC and per-wheel PID steps, holds the output register.
`default_nettype none
module asp_control #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output asp_pkg::cmd_t            cmd,
  output logic                     cmd_valid,
  input  wire logic signed [31:0]  force_in,
  output logic signed [31:0]       left_force,
  output logic signed [31:0]       right_force
);

  localparam logic [2:0] ST_IDLE = 3'd0, ST_ROT = 3'd1, ST_TRK = 3'd2, ST_VEC = 3'd3,
                         ST_RND = 3'd4, ST_WHL = 3'd5, ST_DONE = 3'd6;
  localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

  logic [2:0] st_r, st_nxt;
  logic [4:0] it_r, it_nxt;
  logic [2:0] sub_r, sub_nxt;
  logic       wh_r, wh_nxt, ov_r, ov_nxt;
  logic signed [31:0] lf_r, lf_nxt, rf_r, rf_nxt;
  logic       fin;

  // A new item waits until the previous result has been transferred.
  assign in_ready = (st_r == ST_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign left_force = lf_r;
  assign right_force = rf_r;

  always_comb begin
    st_nxt = st_r; it_nxt = it_r; sub_nxt = sub_r; wh_nxt = wh_r;
    ov_nxt = ov_r; lf_nxt = lf_r; rf_nxt = rf_r; fin = 1'b0;
    cmd = '{op: asp_pkg::OP_LOAD, wheel: wh_r, iter: it_r};
    cmd_valid = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: if (in_valid && in_ready) begin
        cmd_valid = 1'b1; st_nxt = ST_ROT; it_nxt = '0;
      end
      ST_ROT: begin
        cmd.op = asp_pkg::OP_ROT; cmd_valid = 1'b1;
        it_nxt = it_r + 5'd1;
        if (it_r == LAST) begin it_nxt = '0; st_nxt = ST_TRK; end
      end
      ST_TRK: begin
        cmd.op = asp_pkg::OP_TRACK; cmd_valid = 1'b1; st_nxt = ST_VEC;
      end
      ST_VEC: begin
        cmd.op = asp_pkg::OP_VEC; cmd_valid = 1'b1;
        it_nxt = it_r + 5'd1;
        if (it_r == LAST) begin it_nxt = '0; st_nxt = ST_RND; end
      end
      ST_RND: begin
        cmd.op = asp_pkg::OP_ROUND; cmd_valid = 1'b1;
        st_nxt = ST_WHL; sub_nxt = '0; wh_nxt = 1'b0;
      end
      ST_WHL: begin
        cmd_valid = 1'b1;
        unique case (sub_r)
          3'd0: cmd.op = asp_pkg::OP_SMOOTH;
          3'd1: cmd.op = asp_pkg::OP_SNAP;
          3'd2: cmd.op = asp_pkg::OP_INTEG;
          3'd3: cmd.op = asp_pkg::OP_PTERM;
          3'd4: cmd.op = asp_pkg::OP_ITERM;
          3'd5: cmd.op = asp_pkg::OP_DTERM;
          3'd6: cmd.op = asp_pkg::OP_FORCE;
          default: begin cmd.op = asp_pkg::OP_FORCE; cmd_valid = 1'b0; fin = 1'b1; end
        endcase
        sub_nxt = sub_r + 3'd1;
        if (fin) begin
          if (wh_r) rf_nxt = force_in; else lf_nxt = force_in;
          sub_nxt = '0; wh_nxt = !wh_r;
          if (wh_r) st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        ov_nxt = 1'b1; st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
    end
    it_r <= it_nxt; sub_r <= sub_nxt; wh_r <= wh_nxt;
    lf_r <= lf_nxt; rf_r <= rf_nxt;
  end

endmodule
`default_nettype wire

/* src/ackermann_steering_pid_core.sv */
// Top level of the Ackermann steering PID core.
// Each accepted transfer in gives one transfer out. The shared CORDIC iterates one step a
// cycle, and the smoothing, integral and PID steps are taken for each wheel in turn.
// Items are taken one at a time; the next is accepted once the previous result has been
// transferred. Configuration writes are taken at any clock with cfg_we high and should
// arrive while idle.
`default_nettype none
module ackermann_steering_pid_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire asp_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output asp_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);

  logic [23:0] kp_r, ki_r, kd_r;
  logic [15:0] sm_r, tr_r;
  logic [14:0] sn_r;
  asp_pkg::cmd_t cmd;
  logic cmd_valid;
  logic signed [31:0] force_w;
  logic signed [31:0] lf_w, rf_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= 24'd48150; ki_r <= 24'd1937; kd_r <= 24'd3228584;
      sm_r <= 16'd66; sn_r <= 15'd82; tr_r <= 16'd17929;
    end else if (cfg_we) begin
      unique case (cfg_index)
        asp_pkg::REG_PROP:   kp_r <= cfg_data;
        asp_pkg::REG_INTEG:  ki_r <= cfg_data;
        asp_pkg::REG_DERIV:  kd_r <= cfg_data;
        asp_pkg::REG_SMOOTH: sm_r <= cfg_data[15:0];
        asp_pkg::REG_SNAP:   sn_r <= cfg_data[14:0];
        asp_pkg::REG_TRACK:  tr_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  asp_control #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .cmd, .cmd_valid, .force_in(force_w),
    .left_force(lf_w), .right_force(rf_w)
  );

  assign out_data = '{left_force: lf_w, right_force: rf_w};

  asp_datapath u_dp (
    .clk, .rst_n, .cmd, .cmd_valid, .item(in_data),
    .prop_gain(kp_r), .integ_gain(ki_r), .deriv_gain(kd_r),
    .smooth_coef(sm_r), .snap_limit(sn_r), .track_ratio(tr_r),
    .force_out(force_w)
  );

endmodule
`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the Ackermann steering PID core.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int STEPS   = 16;
  localparam int LATENCY = 2 * STEPS + 21;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  asp_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  asp_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = asp_pkg::REG_PROP;
  logic [23:0] cfg_data = '0;

  ackermann_steering_pid_core #(.CORDIC_STEPS(STEPS)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Shadow copy of the registers and the wheel state.
  longint kp, ki, kd, alpha, snap, track;
  int left_des, right_des, left_int, right_int;
  asp_pkg::out_item_t force_q[$];
  int errors = 0;
  int long_hold = 0;

  localparam longint ARC_TAB [0:23] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint outer_wheel_angle(longint a13);
    longint x, y, z, nx, ny;
    x = 64'sd1 <<< 24;
    y = 0;
    z = a13 * 2048;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ARC_TAB[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ARC_TAB[i];
      end
      x = nx; y = ny;
    end
    x += (track * y) >>> 15;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ARC_TAB[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ARC_TAB[i];
      end
      x = nx; y = ny;
    end
    return (z + 1024) >>> 11;
  endfunction

  function automatic logic [31:0] wheel_force(inout int des, inout int integ,
                                             input longint tgt13, input longint ang13,
                                             input longint rate11);
    longint t, d, diff, e29, sum;
    t = tgt13 * 65536;
    d = des;
    d += (alpha * (t - d)) >>> 16;
    diff = t - d;
    if (diff < 0) diff = -diff;
    if (diff < snap * 65536) d = t;
    des = int'(d);
    e29 = d - ang13 * 65536;
    integ = int'(sat32(longint'(integ) + ((e29 + 32768) >>> 16)));
    sum = ((kp * e29) >>> 16) + ki * longint'(integ) - kd * rate11 * 4;
    return 32'(sat32((sum + 2048) >>> 12));
  endfunction

  function automatic asp_pkg::out_item_t predict_forces(asp_pkg::in_item_t it);
    longint s, lt, rt;
    asp_pkg::out_item_t r;
    s = longint'($signed(it.steer_request));
    lt = 0;
    rt = 0;
    if (s > 12867) s = 12867;
    if (s < -12867) s = -12867;
    if (s > 0) begin
      lt = s;
      rt = outer_wheel_angle(s);
    end else if (s < 0) begin
      lt = -outer_wheel_angle(-s);
      rt = s;
    end
    r.left_force = wheel_force(left_des, left_int, lt, longint'($signed(it.left_angle)),
                               longint'($signed(it.left_rate)));
    r.right_force = wheel_force(right_des, right_int, rt,
                                longint'($signed(it.right_angle)),
                                longint'($signed(it.right_rate)));
    return r;
  endfunction

  task automatic send_item(input asp_pkg::in_item_t it);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    force_q.push_back(predict_forces(it));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain_results();
    while (force_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      asp_pkg::REG_PROP:   kp = val;
      asp_pkg::REG_INTEG:  ki = val;
      asp_pkg::REG_DERIV:  kd = val;
      asp_pkg::REG_SMOOTH: alpha = val[15:0];
      asp_pkg::REG_SNAP:   snap = val[14:0];
      asp_pkg::REG_TRACK:  track = val[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [23:0] p, input logic [23:0] i, input logic [23:0] d,
                           input logic [15:0] a, input logic [14:0] sn,
                           input logic [15:0] tr);
    drain_results();
    write_reg(asp_pkg::REG_PROP, p);
    write_reg(asp_pkg::REG_INTEG, i);
    write_reg(asp_pkg::REG_DERIV, d);
    write_reg(asp_pkg::REG_SMOOTH, {8'd0, a});
    write_reg(asp_pkg::REG_SNAP, {9'd0, sn});
    write_reg(asp_pkg::REG_TRACK, {8'd0, tr});
  endtask

  function automatic asp_pkg::in_item_t make_item(logic signed [14:0] s,
                                                  logic signed [15:0] la,
                                                  logic signed [15:0] lr,
                                                  logic signed [15:0] ra,
                                                  logic signed [15:0] rr);
    asp_pkg::in_item_t it;
    it.steer_request = s;
    it.left_angle = la;
    it.left_rate = lr;
    it.right_angle = ra;
    it.right_rate = rr;
    return it;
  endfunction

  // Mostly plausible ticks: wheel angles near their desired values, modest rates.
  function automatic asp_pkg::in_item_t random_item();
    asp_pkg::in_item_t it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(asp_pkg::in_item_t)-1:0];
    if ($urandom_range(0, 9) != 0) begin
      it.steer_request = ($urandom_range(0, 3) == 0) ? 15'($signed($urandom_range(0, 400)) - 200)
                                                    : 15'($signed($urandom_range(0, 25734)) - 12867);
      it.left_angle = 16'((left_des >>> 16) + $signed($urandom_range(0, 600)) - 300);
      it.right_angle = 16'((right_des >>> 16) + $signed($urandom_range(0, 600)) - 300);
      it.left_rate = 16'($signed($urandom_range(0, 4096)) - 2048);
      it.right_rate = 16'($signed($urandom_range(0, 4096)) - 2048);
    end
    return it;
  endfunction

  task automatic run_random(input int n);
    repeat (n) send_item(random_item());
  endtask

  task automatic test_directed();
    send_item(make_item(15'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(make_item(15'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(make_item(-15'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(make_item(15'sd12867, 16'sd12000, 16'sd100, 16'sd9000, -16'sd100));
    send_item(make_item(-15'sd12867, -16'sd12000, -16'sd100, -16'sd9000, 16'sd100));
    // Requests beyond the limit are clamped.
    send_item(make_item(15'sd16383, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767));
    send_item(make_item(-15'sd16384, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768));
    send_item(make_item(15'sd12868, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(make_item(-15'sd12868, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(make_item(15'sd6433, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768));
    send_item(make_item(-15'sd6433, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767));
    send_item(make_item(15'sd0, 16'sd32767, 16'sd0, -16'sd32768, 16'sd0));
    // Long run of a large error to build up the integrals.
    repeat (8) send_item(make_item(15'sd12867, -16'sd32768, 16'sd0, -16'sd32768, 16'sd0));
  endtask

  task automatic test_register_settings();
    write_all(24'd0, 24'd0, 24'd0, 16'd0, 15'd0, 16'd0);
    run_random(150);
    write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 15'h7FFF, 16'hFFFF);
    test_directed();
    run_random(150);
    write_all(24'd48150, 24'd1937, 24'd3228584, 16'hFFFF, 15'd0, 16'd0);
    run_random(150);
    write_all(24'd4096, 24'd0, 24'd0, 16'd1, 15'd0, 16'hFFFF);
    run_random(150);
    repeat (4) begin
      write_all(24'($urandom), 24'($urandom_range(0, 20000)), 24'($urandom),
                16'($urandom), 15'($urandom_range(0, 500)), 16'($urandom));
      run_random(150);
    end
  endtask

  task automatic test_backpressure();
    drain_results();
    write_all(24'd48150, 24'd1937, 24'd3228584, 16'd66, 15'd82, 16'd17929);
    long_hold = 300;
    run_random(20);
    drain_results();
    run_random(100);
  endtask

  // Receiver: random stalls, with an occasional long hold-off on request.
  initial begin
    int k;
    asp_pkg::out_item_t want;
    forever begin
      @(negedge clk);
      k = $urandom_range(0, 3);
      if (long_hold != 0) begin
        k = long_hold;
        long_hold = 0;
      end
      if (k != 0) begin
        out_ready = 1'b0;
        repeat (k) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (force_q.size() == 0) begin
        $error("unexpected result transfer: %h", out_data);
        errors++;
      end else begin
        want = force_q.pop_front();
        if (out_data.left_force !== want.left_force) begin
          $error("left_force: expected %0d, got %0d", $signed(want.left_force),
                 $signed(out_data.left_force));
          errors++;
        end
        if (out_data.right_force !== want.right_force) begin
          $error("right_force: expected %0d, got %0d", $signed(want.right_force),
                 $signed(out_data.right_force));
          errors++;
        end
      end
    end
  end

  initial begin
    kp = 48150; ki = 1937; kd = 3228584; alpha = 66; snap = 82; track = 17929;
    left_des = 0; right_des = 0; left_int = 0; right_int = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    run_random(200);
    test_register_settings();
    test_backpressure();
    drain_results();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* ackermann_steering_pid_core.f */
src/asp_pkg.sv
src/asp_datapath.sv
src/asp_control.sv
src/ackermann_steering_pid_core.sv
sim/tb.sv
